>>> src/calendar_date_stepper_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the calendar date stepper
// Concurrent checks that are active in simulation and empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_DATE_STEPPER_TOP_ASSERT_SVH
`define CALENDAR_DATE_STEPPER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge while out of reset.
`define CDS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cds assertion failed");

// Check a property on every clock edge, reset included.
`define CDS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("cds assertion failed");

`else

`define CDS_ASSERT(label, clk, rst_n, prop)
`define CDS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> src/cds_pkg.sv
// ---------------------------------------------------------------------------
// cds_pkg
// Types, constants and calendar helper functions of the date stepper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cds_pkg;

  // Field widths
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned R400_W  = 9;

  // Default year range
  localparam int unsigned MIN_YEAR_DEF = 1753;
  localparam int unsigned MAX_YEAR_DEF = 9999;

  // Queue depths
  localparam int unsigned CMD_Q_DEPTH = 2;
  localparam int unsigned OUT_Q_DEPTH = 8;

  // Reciprocal multipliers for constant division (exact over the operand range)
  localparam int unsigned DIV400_M = 10486;
  localparam int unsigned DIV400_S = 22;
  localparam int unsigned DIV100_M = 20972;
  localparam int unsigned DIV100_S = 21;
  localparam int unsigned DIV7_M   = 1171;
  localparam int unsigned DIV7_S   = 13;

  // Operation codes, numbered as on the opcode field
  typedef enum logic [OP_W-1:0] {
    OP_QUERY      = 4'd0,
    OP_SET_DATE   = 4'd1,
    OP_SET_YEAR   = 4'd2,
    OP_SET_MONTH  = 4'd3,
    OP_SET_DAY    = 4'd4,
    OP_NEXT_DAY   = 4'd5,
    OP_PREV_DAY   = 4'd6,
    OP_NEXT_MONTH = 4'd7,
    OP_PREV_MONTH = 4'd8,
    OP_NEXT_YEAR  = 4'd9,
    OP_PREV_YEAR  = 4'd10
  } cds_op_t;

  // Status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } cds_status_t;

  // Month numbers that matter to the logic
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  // Input item
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [YEAR_W-1:0]  year_in;
    logic [MONTH_W-1:0] month_in;
    logic [DAY_W-1:0]   day_in;
  } cds_in_t;

  // Result item
  typedef struct packed {
    logic [YEAR_W-1:0]  year_out;
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;
    logic [WDAY_W-1:0]  weekday;
    logic [STAT_W-1:0]  status;
  } cds_out_t;

  // Classified command from front to back
  typedef struct packed {
    cds_op_t            op;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               year_ok;
    logic [R400_W-1:0]  year_r400;
  } cds_cmd_t;

  // Date after execution, before the weekday is known
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    cds_status_t        status;
  } cds_date_t;

  // Leap year from the year modulo 400
  function automatic logic leap400(input logic [R400_W-1:0] r);
    logic not_century;
    begin
      not_century = (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
      return (r[1:0] == 2'b00) && not_century;
    end
  endfunction

  // Days in a month, zero for a month number out of range
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    begin
      unique case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
        4'd2:    len = leap ? 5'd29 : 5'd28;
        default: len = 5'd0;
      endcase
      return len;
    end
  endfunction

  // Month term of the weekday formula: floor(26 * (mm + 1) / 10), mm in 3..14
  function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] mm);
    logic [5:0] t;
    begin
      unique case (mm)
        4'd3:    t = 6'd10;
        4'd4:    t = 6'd13;
        4'd5:    t = 6'd15;
        4'd6:    t = 6'd18;
        4'd7:    t = 6'd20;
        4'd8:    t = 6'd23;
        4'd9:    t = 6'd26;
        4'd10:   t = 6'd28;
        4'd11:   t = 6'd31;
        4'd12:   t = 6'd33;
        4'd13:   t = 6'd36;
        4'd14:   t = 6'd39;
        default: t = 6'd0;
      endcase
      return t;
    end
  endfunction

endpackage

>>> src/cds_fifo.sv
// ---------------------------------------------------------------------------
// cds_fifo
// Small register queue with occupancy count, used on both sides of the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cds_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;
  assign rdata = slot_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers with wrap, track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> src/cds_front.sv
// ---------------------------------------------------------------------------
// cds_front
// Accepts input items, decodes the opcode, checks the year operand and
// queues the classified command for the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cds_front #(
  parameter int unsigned MIN_YEAR = cds_pkg::MIN_YEAR_DEF,
  parameter int unsigned MAX_YEAR = cds_pkg::MAX_YEAR_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  cds_pkg::cds_in_t  in_data,
  output logic              in_full,
  input  logic              q_pop,
  output cds_pkg::cds_cmd_t q_data,
  output logic              q_empty
);

  localparam int unsigned YW   = cds_pkg::YEAR_W;
  localparam int unsigned PROD_W = YW + 14;
  localparam logic [YW-1:0] MIN_Y = YW'(MIN_YEAR);
  localparam logic [YW-1:0] MAX_Y = YW'(MAX_YEAR);

  cds_pkg::cds_cmd_t  cmd;
  logic [PROD_W-1:0]  q400_prod;
  logic [YW-1:0]      q400;
  logic [YW-1:0]      r400_full;

  // Year operand modulo 400 by reciprocal multiply
  assign q400_prod = PROD_W'(in_data.year_in) * PROD_W'(cds_pkg::DIV400_M);
  assign q400      = YW'(q400_prod >> cds_pkg::DIV400_S);
  assign r400_full = in_data.year_in - q400 * YW'(400);

  // Classify the opcode; unused codes behave as a query
  always_comb begin
    cmd.year      = in_data.year_in;
    cmd.month     = in_data.month_in;
    cmd.day       = in_data.day_in;
    cmd.year_ok   = (in_data.year_in >= MIN_Y) && (in_data.year_in <= MAX_Y);
    cmd.year_r400 = r400_full[cds_pkg::R400_W-1:0];
    priority if (in_data.opcode > cds_pkg::OP_PREV_YEAR) begin
      cmd.op = cds_pkg::OP_QUERY;
    end else begin
      cmd.op = cds_pkg::cds_op_t'(in_data.opcode);
    end
  end

  // Command queue between front and back
  cds_fifo #(
    .WIDTH ($bits(cds_pkg::cds_cmd_t)),
    .DEPTH (cds_pkg::CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty),
    .count ()
  );

endmodule

>>> src/cds_exec.sv
// ---------------------------------------------------------------------------
// cds_exec
// Holds the current date and runs one command per cycle if there is room:
// sets with validity check, day, month and year steps with range limits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "calendar_date_stepper_top_assert.svh"

module cds_exec #(
  parameter int unsigned MIN_YEAR = cds_pkg::MIN_YEAR_DEF,
  parameter int unsigned MAX_YEAR = cds_pkg::MAX_YEAR_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  cds_pkg::cds_cmd_t  q_data,
  input  logic               room,
  output logic               q_pop,
  output logic               res_vld,
  output cds_pkg::cds_date_t res
);

  localparam int unsigned YW = cds_pkg::YEAR_W;
  localparam int unsigned MW = cds_pkg::MONTH_W;
  localparam int unsigned DW = cds_pkg::DAY_W;
  localparam int unsigned RW = cds_pkg::R400_W;
  localparam logic [YW-1:0] MIN_Y    = YW'(MIN_YEAR);
  localparam logic [YW-1:0] MAX_Y    = YW'(MAX_YEAR);
  localparam int unsigned   R400_RST = MIN_YEAR % 400;

  logic [YW-1:0] cur_y_r, cur_y_nxt;
  logic [MW-1:0] cur_m_r, cur_m_nxt;
  logic [DW-1:0] cur_d_r, cur_d_nxt;
  logic [RW-1:0] cur_r400_r, cur_r400_nxt;
  cds_pkg::cds_status_t st;

  logic               res_vld_r;
  cds_pkg::cds_date_t res_r;

  logic          leap_cur, leap_cmd;
  logic [DW-1:0] len_cur, len_set, len_new;
  logic [RW-1:0] r400_inc, r400_dec;
  logic          at_max, at_min;

  logic               rejected;
  logic [YW+MW+DW-1:0] cur_date;

  assign q_pop = !q_empty && room;

  assign leap_cur = cds_pkg::leap400(cur_r400_r);
  assign leap_cmd = cds_pkg::leap400(q_data.year_r400);
  assign len_cur  = cds_pkg::month_len(cur_m_r, leap_cur);
  assign r400_inc = (cur_r400_r == RW'(399)) ? '0 : cur_r400_r + RW'(1);
  assign r400_dec = (cur_r400_r == '0) ? RW'(399) : cur_r400_r - RW'(1);
  assign at_max   = (cur_y_r >= MAX_Y);
  assign at_min   = (cur_y_r <= MIN_Y);

  // Apply the command to the current date
  always_comb begin
    cur_y_nxt    = cur_y_r;
    cur_m_nxt    = cur_m_r;
    cur_d_nxt    = cur_d_r;
    cur_r400_nxt = cur_r400_r;
    st           = cds_pkg::ST_OK;
    len_set      = '0;
    len_new      = '0;
    unique case (q_data.op)
      cds_pkg::OP_SET_DATE: begin
        len_set = cds_pkg::month_len(q_data.month, leap_cmd);
        if (q_data.year_ok && q_data.day != '0 && q_data.day <= len_set) begin
          cur_y_nxt    = q_data.year;
          cur_m_nxt    = q_data.month;
          cur_d_nxt    = q_data.day;
          cur_r400_nxt = q_data.year_r400;
        end else begin
          st = cds_pkg::ST_INVALID;
        end
      end
      cds_pkg::OP_SET_YEAR: begin
        len_set = cds_pkg::month_len(cur_m_r, leap_cmd);
        if (q_data.year_ok && cur_d_r <= len_set) begin
          cur_y_nxt    = q_data.year;
          cur_r400_nxt = q_data.year_r400;
        end else begin
          st = cds_pkg::ST_INVALID;
        end
      end
      cds_pkg::OP_SET_MONTH: begin
        len_set = cds_pkg::month_len(q_data.month, leap_cur);
        if (cur_d_r <= len_set) begin
          cur_m_nxt = q_data.month;
        end else begin
          st = cds_pkg::ST_INVALID;
        end
      end
      cds_pkg::OP_SET_DAY: begin
        if (q_data.day != '0 && q_data.day <= len_cur) begin
          cur_d_nxt = q_data.day;
        end else begin
          st = cds_pkg::ST_INVALID;
        end
      end
      cds_pkg::OP_NEXT_DAY: begin
        if (at_max && cur_m_r == cds_pkg::MON_DEC && cur_d_r == DW'(31)) begin
          st = cds_pkg::ST_RANGE;
        end else if (cur_d_r < len_cur) begin
          cur_d_nxt = cur_d_r + DW'(1);
        end else begin
          cur_d_nxt = DW'(1);
          if (cur_m_r < cds_pkg::MON_DEC) begin
            cur_m_nxt = cur_m_r + MW'(1);
          end else begin
            cur_m_nxt    = cds_pkg::MON_JAN;
            cur_y_nxt    = cur_y_r + YW'(1);
            cur_r400_nxt = r400_inc;
          end
        end
      end
      cds_pkg::OP_PREV_DAY: begin
        if (at_min && cur_m_r == cds_pkg::MON_JAN && cur_d_r == DW'(1)) begin
          st = cds_pkg::ST_RANGE;
        end else if (cur_d_r > DW'(1)) begin
          cur_d_nxt = cur_d_r - DW'(1);
        end else if (cur_m_r > cds_pkg::MON_JAN) begin
          cur_m_nxt = cur_m_r - MW'(1);
          cur_d_nxt = cds_pkg::month_len(cur_m_r - MW'(1), leap_cur);
        end else begin
          cur_m_nxt    = cds_pkg::MON_DEC;
          cur_d_nxt    = DW'(31);
          cur_y_nxt    = cur_y_r - YW'(1);
          cur_r400_nxt = r400_dec;
        end
      end
      cds_pkg::OP_NEXT_MONTH: begin
        if (at_max && cur_m_r == cds_pkg::MON_DEC) begin
          st = cds_pkg::ST_RANGE;
        end else begin
          if (cur_m_r < cds_pkg::MON_DEC) begin
            cur_m_nxt = cur_m_r + MW'(1);
            len_new   = cds_pkg::month_len(cur_m_r + MW'(1), leap_cur);
          end else begin
            cur_m_nxt    = cds_pkg::MON_JAN;
            cur_y_nxt    = cur_y_r + YW'(1);
            cur_r400_nxt = r400_inc;
            len_new      = DW'(31);
          end
          if (cur_d_r > len_new) begin
            cur_d_nxt = len_new;
          end
        end
      end
      cds_pkg::OP_PREV_MONTH: begin
        if (at_min && cur_m_r == cds_pkg::MON_JAN) begin
          st = cds_pkg::ST_RANGE;
        end else begin
          if (cur_m_r > cds_pkg::MON_JAN) begin
            cur_m_nxt = cur_m_r - MW'(1);
            len_new   = cds_pkg::month_len(cur_m_r - MW'(1), leap_cur);
          end else begin
            cur_m_nxt    = cds_pkg::MON_DEC;
            cur_y_nxt    = cur_y_r - YW'(1);
            cur_r400_nxt = r400_dec;
            len_new      = DW'(31);
          end
          if (cur_d_r > len_new) begin
            cur_d_nxt = len_new;
          end
        end
      end
      cds_pkg::OP_NEXT_YEAR: begin
        if (at_max) begin
          st = cds_pkg::ST_RANGE;
        end else begin
          cur_y_nxt    = cur_y_r + YW'(1);
          cur_r400_nxt = r400_inc;
          if (cur_m_r == cds_pkg::MON_FEB && cur_d_r == DW'(29)) begin
            cur_d_nxt = DW'(28);
          end
        end
      end
      cds_pkg::OP_PREV_YEAR: begin
        if (at_min) begin
          st = cds_pkg::ST_RANGE;
        end else begin
          cur_y_nxt    = cur_y_r - YW'(1);
          cur_r400_nxt = r400_dec;
          if (cur_m_r == cds_pkg::MON_FEB && cur_d_r == DW'(29)) begin
            cur_d_nxt = DW'(28);
          end
        end
      end
      default: begin
        // query: hold the date
      end
    endcase
  end

  // Update the date on each transfer from the command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_y_r    <= MIN_Y;
      cur_m_r    <= cds_pkg::MON_JAN;
      cur_d_r    <= DW'(1);
      cur_r400_r <= RW'(R400_RST);
      res_vld_r  <= 1'b0;
    end else begin
      res_vld_r <= q_pop;
      if (q_pop) begin
        cur_y_r    <= cur_y_nxt;
        cur_m_r    <= cur_m_nxt;
        cur_d_r    <= cur_d_nxt;
        cur_r400_r <= cur_r400_nxt;
      end
    end
  end

  // Register the result for the weekday pipeline
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r.year   <= cur_y_nxt;
      res_r.month  <= cur_m_nxt;
      res_r.day    <= cur_d_nxt;
      res_r.status <= st;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

  // Flag a rejected command on the result register
  assign rejected = res_vld_r && (res_r.status != cds_pkg::ST_OK);
  assign cur_date = {cur_y_r, cur_m_r, cur_d_r};

  `CDS_ASSERT(a_year_in_range, clk, rst_n, cur_y_r >= MIN_Y && cur_y_r <= MAX_Y)
  `CDS_ASSERT(a_day_fits_month, clk, rst_n, cur_d_r != '0 && cur_d_r <= len_cur)
  `CDS_ASSERT(a_r400_bounded, clk, rst_n, cur_r400_r < RW'(400))
  `CDS_ASSERT(a_reject_holds_date, clk, rst_n, rejected |-> $stable(cur_date))

endmodule

>>> src/cds_weekday.sv
// ---------------------------------------------------------------------------
// cds_weekday
// Two-stage pipeline that appends the day of week (0 Sunday) to a date.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cds_weekday (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_vld,
  input  cds_pkg::cds_date_t res,
  output logic               out_vld,
  output cds_pkg::cds_out_t  out_item,
  output logic [1:0]         busy
);

  localparam int unsigned YW     = cds_pkg::YEAR_W;
  localparam int unsigned MW     = cds_pkg::MONTH_W;
  localparam int unsigned DW     = cds_pkg::DAY_W;
  localparam int unsigned C_W    = 8;
  localparam int unsigned K_W    = 7;
  localparam int unsigned P100_W = YW + 15;
  localparam int unsigned S_W    = 11;
  localparam int unsigned P7_W   = S_W + 11;

  // stage A: century split
  logic               a_vld_r;
  cds_pkg::cds_date_t a_date_r;
  logic [C_W-1:0]     a_c_r;
  logic [K_W-1:0]     a_k_r;
  logic [MW-1:0]      a_mm_r;

  // stage B: weekday sum
  logic               b_vld_r;
  cds_pkg::cds_date_t b_date_r;
  logic [S_W-1:0]     b_s_r;

  logic               lt_mar;
  logic [MW-1:0]      mm;
  logic [YW-1:0]      yy;
  logic [P100_W-1:0]  c_prod;
  logic [C_W-1:0]     c_val;
  logic [YW-1:0]      k_full;
  logic [S_W-1:0]     s_val;
  logic [P7_W-1:0]    q7_prod;
  logic [S_W-1:0]     q7;
  logic [S_W-1:0]     r7;

  // Shift January and February to the end of the previous year
  assign lt_mar = (res.month < cds_pkg::MON_MAR);
  assign mm     = lt_mar ? res.month + MW'(12) : res.month;
  assign yy     = res.year - YW'(lt_mar);
  assign c_prod = P100_W'(yy) * P100_W'(cds_pkg::DIV100_M);
  assign c_val  = C_W'(c_prod >> cds_pkg::DIV100_S);
  assign k_full = yy - YW'(c_val) * YW'(100);

  always_ff @(posedge clk) begin
    a_date_r <= res;
    a_c_r    <= c_val;
    a_k_r    <= k_full[K_W-1:0];
    a_mm_r   <= mm;
  end

  // Sum the Zeller terms; the offset keeps the sum positive and is 6 mod 7, so 0 is Sunday
  assign s_val = S_W'(a_k_r) + S_W'(a_k_r >> 2) + S_W'(a_c_r >> 2)
               + S_W'(cds_pkg::month_term(a_mm_r)) + S_W'(a_date_r.day)
               + S_W'(699) - (S_W'(a_c_r) << 1);

  always_ff @(posedge clk) begin
    b_date_r <= a_date_r;
    b_s_r    <= s_val;
  end

  // Reduce modulo 7 by reciprocal multiply
  assign q7_prod = P7_W'(b_s_r) * P7_W'(cds_pkg::DIV7_M);
  assign q7      = S_W'(q7_prod >> cds_pkg::DIV7_S);
  assign r7      = b_s_r - q7 * S_W'(7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= res_vld;
      b_vld_r <= a_vld_r;
    end
  end

  assign out_vld            = b_vld_r;
  assign out_item.year_out  = b_date_r.year;
  assign out_item.month_out = b_date_r.month;
  assign out_item.day_out   = b_date_r.day;
  assign out_item.weekday   = r7[cds_pkg::WDAY_W-1:0];
  assign out_item.status    = b_date_r.status;
  assign busy               = {1'b0, a_vld_r} + {1'b0, b_vld_r};

endmodule

>>> src/calendar_date_stepper_top.sv
// ---------------------------------------------------------------------------
// calendar_date_stepper_top
// Gregorian date register with set, step and query commands and weekday.
// ---------------------------------------------------------------------------
// Takes one command per cycle while in_full is low and returns one result
// per command, in order. A command goes through a two-entry command queue,
// the date execution stage, which updates the year, month and day
// registers, and two weekday stages before it lands in an eight-entry
// result queue. The sustained rate is one item per clock while the result
// queue has room, bounded by the date update that each command needs from
// the one before; the back holds commands only when the result queue plus
// items in flight would exceed its eight entries.
`timescale 1ns / 1ps

`include "calendar_date_stepper_top_assert.svh"

module calendar_date_stepper_top #(
  parameter int unsigned MIN_YEAR = cds_pkg::MIN_YEAR_DEF,
  parameter int unsigned MAX_YEAR = cds_pkg::MAX_YEAR_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  cds_pkg::cds_in_t  in_data,
  output logic              in_full,
  output logic              out_empty,
  input  logic              out_pop,
  output cds_pkg::cds_out_t out_data
);

  localparam int unsigned OCW = $clog2(cds_pkg::OUT_Q_DEPTH+1);
  localparam int unsigned FW  = OCW + 1;

  cds_pkg::cds_cmd_t  q_data;
  logic               q_empty, q_pop;
  logic               room;
  logic               res_vld;
  cds_pkg::cds_date_t res;
  logic               wd_vld;
  cds_pkg::cds_out_t  wd_item;
  logic [1:0]         wd_busy;
  logic               out_full;
  logic [OCW-1:0]     out_count;
  logic [FW-1:0]      in_flight;

  // Front: classify and queue commands
  cds_front #(
    .MIN_YEAR (MIN_YEAR),
    .MAX_YEAR (MAX_YEAR)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_pop   (q_pop),
    .q_data  (q_data),
    .q_empty (q_empty)
  );

  // Reserve a result slot for every item past the command queue
  assign in_flight = FW'(out_count) + FW'(res_vld) + FW'(wd_busy);
  assign room      = (in_flight < FW'(cds_pkg::OUT_Q_DEPTH));

  // Back: date update
  cds_exec #(
    .MIN_YEAR (MIN_YEAR),
    .MAX_YEAR (MAX_YEAR)
  ) u_exec (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_data),
    .room    (room),
    .q_pop   (q_pop),
    .res_vld (res_vld),
    .res     (res)
  );

  // Back: weekday
  cds_weekday u_weekday (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_vld  (res_vld),
    .res      (res),
    .out_vld  (wd_vld),
    .out_item (wd_item),
    .busy     (wd_busy)
  );

  // Result queue
  cds_fifo #(
    .WIDTH ($bits(cds_pkg::cds_out_t)),
    .DEPTH (cds_pkg::OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (wd_vld),
    .wdata (wd_item),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty),
    .count (out_count)
  );

  `CDS_ASSERT(a_no_push_when_full, clk, rst_n, wd_vld |-> !out_full)
  `CDS_ASSERT(a_pop_needs_cmd, clk, rst_n, q_pop |-> !q_empty)
  `CDS_ASSERT(a_credit_bound, clk, rst_n, in_flight <= FW'(cds_pkg::OUT_Q_DEPTH))
  `CDS_ASSERT_ALWAYS(a_reset_clears_back, clk, !rst_n |=> !res_vld && out_empty)

endmodule
